// ===== hw/rtl/maze_backtracker_generator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Maze generator assertion macros
// Shared assertion forms for the maze backtracker generator core.
// ----------------------------------------------------------------------------
`ifndef MAZE_BACKTRACKER_GENERATOR_CORE_DEFINES_SVH
`define MAZE_BACKTRACKER_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mbg_pkg.sv =====
// ----------------------------------------------------------------------------
// Maze generator package
// Sizes, codes and shared types of the maze backtracker generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbg_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
    localparam int CNT_W       = $clog2(CELLS + 1);
    localparam int SIZE_W      = 7;
    localparam int CELL_W      = 5;
    localparam int RND_W       = 8;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [CELL_W-1:0] OPEN_N  = 5'h01;
    localparam logic [CELL_W-1:0] OPEN_E  = 5'h02;
    localparam logic [CELL_W-1:0] OPEN_S  = 5'h04;
    localparam logic [CELL_W-1:0] OPEN_W  = 5'h08;
    localparam logic [CELL_W-1:0] VISITED = 5'h10;

    // Scan slot after the four neighbors: the stack-top cell itself.
    localparam logic [2:0] SCAN_SELF = 3'd4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CARVED      = 3'd0,
        ST_BACKTRACKED = 3'd1,
        ST_NOOP        = 3'd2,
        ST_READ_DONE   = 3'd3,
        ST_STARTED     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_INIT,
        S_CLEAR,
        S_START_FIN,
        S_SCAN,
        S_PICK,
        S_WR_TOP,
        S_WR_NEW,
        S_POP_RD,
        S_POP_CAP,
        S_READ,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    start_init;
        logic    clr_step;
        logic    start_fin;
        logic    scan_issue;
        logic    pick;
        logic    wr_top;
        logic    wr_new;
        logic    pop_issue;
        logic    pop_cap;
        logic    read_issue;
        logic    finish;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        logic step_ok;
        logic scan_last;
        logic clr_last;
        logic any_open;
        logic out_busy;
    } sts_t;

    function automatic logic [CELL_W-1:0] open_bit(dir_t d);
        logic [CELL_W-1:0] b;
        case (d)
            DIR_N:   b = OPEN_N;
            DIR_E:   b = OPEN_E;
            DIR_S:   b = OPEN_S;
            default: b = OPEN_W;
        endcase
        return b;
    endfunction

    function automatic dir_t opposite(dir_t d);
        return dir_t'({~d[1], d[0]});
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/maze_backtracker_generator_core.sv =====
// ----------------------------------------------------------------------------
// Maze backtracker generator core
// Depth-first maze carving over a grid of up to 64 x 64 cells.
// ----------------------------------------------------------------------------
// The block takes one command beat on the request channel and returns one
// result beat. A carving step or a backtrack reads the four neighbors and the
// stack-top cell one per cycle, since the cell memory has one read port,
// followed by two cell writes (or a stack read on a backtrack). A start runs
// a clearing pass over the whole cell memory; width and height are latched
// at that point. Results sit in an output register, so the next beat is
// accepted while a result still waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "maze_backtracker_generator_core_defines.svh"

module maze_backtracker_generator_core (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [mbg_pkg::PADDR_W-1:0]         paddr,
    input  wire  [mbg_pkg::PDATA_W-1:0]         pwdata,
    output logic [mbg_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  wire                                 req_valid,
    output logic                                req_ready,
    input  wire  [1:0]                          opcode,
    input  wire  [mbg_pkg::COL_W-1:0]           cell_x,
    input  wire  [mbg_pkg::ROW_W-1:0]           cell_y,
    input  wire  [mbg_pkg::RND_W-1:0]           random_value,
    output logic                                rsp_valid,
    input  wire                                 rsp_ready,
    output logic [2:0]                          status,
    output logic [mbg_pkg::COL_W-1:0]           pos_x,
    output logic [mbg_pkg::ROW_W-1:0]           pos_y,
    output logic [1:0]                          carve_dir,
    output logic [mbg_pkg::CELL_W-1:0]          cell_bits,
    output logic [mbg_pkg::CNT_W-1:0]           visited_count
);

    logic [mbg_pkg::SIZE_W-1:0] maze_width_reg;
    logic [mbg_pkg::SIZE_W-1:0] maze_height_reg;
    logic                       apb_wr;
    mbg_pkg::cmd_t              cmd;
    mbg_pkg::sts_t              sts;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    // Address bit 2 selects the register: 0 width, 1 height.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_width_reg  <= mbg_pkg::SIZE_W'(mbg_pkg::MAX_COLUMNS);
            maze_height_reg <= mbg_pkg::SIZE_W'(mbg_pkg::MAX_ROWS);
        end
        else if (apb_wr)
        begin
            if (paddr[2])
            begin
                maze_height_reg <= pwdata[mbg_pkg::SIZE_W-1:0];
            end
            else
            begin
                maze_width_reg <= pwdata[mbg_pkg::SIZE_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? mbg_pkg::PDATA_W'(maze_height_reg)
                             : mbg_pkg::PDATA_W'(maze_width_reg);

    mbg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .opcode    (opcode),
        .sts       (sts),
        .cmd       (cmd)
    );

    mbg_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .random_value  (random_value),
        .cfg_width     (maze_width_reg),
        .cfg_height    (maze_height_reg),
        .cmd           (cmd),
        .sts           (sts),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .carve_dir     (carve_dir),
        .cell_bits     (cell_bits),
        .visited_count (visited_count)
    );

    `MBG_ASSERT_NXT(a_start_blocks, clk, rst_n, req_valid && req_ready && (opcode == mbg_pkg::OP_START), !req_ready, "start did not hold off the request channel")
    `MBG_ASSERT_IMP(a_finish_free, clk, rst_n, cmd.finish, !(rsp_valid && !rsp_ready), "result loaded over a waiting beat")
    `MBG_ASSERT_IMP(a_bits_on_read, clk, rst_n, rsp_valid && (status != mbg_pkg::ST_READ_DONE), cell_bits == '0, "cell bits set on a non-read result")
    `MBG_ASSERT_IMP(a_dir_on_carve, clk, rst_n, rsp_valid && (status != mbg_pkg::ST_CARVED), carve_dir == 2'd0, "direction set on a non-carve result")

endmodule

`default_nettype wire

// ===== hw/rtl/mbg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                               clk,
    input  wire                               we,
    input  wire  [$clog2(DEPTH)-1:0]          waddr,
    input  wire  [WIDTH-1:0]                  wdata,
    input  wire                               re,
    input  wire  [$clog2(DEPTH)-1:0]          raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mbg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Maze generator controller
// Sequences start, carving step, backtrack and read commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbg_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                req_valid,
    output logic               req_ready,
    input  wire  [1:0]         opcode,
    input  mbg_pkg::sts_t      sts,
    output mbg_pkg::cmd_t      cmd
);

    mbg_pkg::state_t  state_reg;
    mbg_pkg::state_t  state_next;
    mbg_pkg::status_t res_status_reg;
    mbg_pkg::status_t res_status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mbg_pkg::S_IDLE;
            res_status_reg <= mbg_pkg::ST_NOOP;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            mbg_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (opcode)
                        mbg_pkg::OP_START:
                        begin
                            state_next = mbg_pkg::S_START_INIT;
                        end
                        mbg_pkg::OP_STEP:
                        begin
                            if (sts.step_ok)
                            begin
                                state_next = mbg_pkg::S_SCAN;
                            end
                            else
                            begin
                                state_next      = mbg_pkg::S_FINISH;
                                res_status_next = mbg_pkg::ST_NOOP;
                            end
                        end
                        default:
                        begin
                            state_next = mbg_pkg::S_READ;
                        end
                    endcase
                end
            end
            mbg_pkg::S_START_INIT:
            begin
                state_next = mbg_pkg::S_CLEAR;
            end
            mbg_pkg::S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = mbg_pkg::S_START_FIN;
                end
            end
            mbg_pkg::S_START_FIN:
            begin
                state_next      = mbg_pkg::S_FINISH;
                res_status_next = mbg_pkg::ST_STARTED;
            end
            mbg_pkg::S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = mbg_pkg::S_PICK;
                end
            end
            mbg_pkg::S_PICK:
            begin
                if (sts.any_open)
                begin
                    state_next      = mbg_pkg::S_WR_TOP;
                    res_status_next = mbg_pkg::ST_CARVED;
                end
                else
                begin
                    state_next      = mbg_pkg::S_POP_RD;
                    res_status_next = mbg_pkg::ST_BACKTRACKED;
                end
            end
            mbg_pkg::S_WR_TOP:
            begin
                state_next = mbg_pkg::S_WR_NEW;
            end
            mbg_pkg::S_WR_NEW:
            begin
                state_next = mbg_pkg::S_FINISH;
            end
            mbg_pkg::S_POP_RD:
            begin
                state_next = mbg_pkg::S_POP_CAP;
            end
            mbg_pkg::S_POP_CAP:
            begin
                state_next = mbg_pkg::S_FINISH;
            end
            mbg_pkg::S_READ:
            begin
                state_next      = mbg_pkg::S_FINISH;
                res_status_next = mbg_pkg::ST_READ_DONE;
            end
            mbg_pkg::S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = mbg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mbg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = res_status_reg;
        req_ready      = 1'b0;
        case (state_reg)
            mbg_pkg::S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.load_item = req_valid;
            end
            mbg_pkg::S_START_INIT: cmd.start_init = 1'b1;
            mbg_pkg::S_CLEAR:      cmd.clr_step   = 1'b1;
            mbg_pkg::S_START_FIN:  cmd.start_fin  = 1'b1;
            mbg_pkg::S_SCAN:       cmd.scan_issue = 1'b1;
            mbg_pkg::S_PICK:       cmd.pick       = 1'b1;
            mbg_pkg::S_WR_TOP:     cmd.wr_top     = 1'b1;
            mbg_pkg::S_WR_NEW:     cmd.wr_new     = 1'b1;
            mbg_pkg::S_POP_RD:     cmd.pop_issue  = 1'b1;
            mbg_pkg::S_POP_CAP:    cmd.pop_cap    = 1'b1;
            mbg_pkg::S_READ:       cmd.read_issue = 1'b1;
            mbg_pkg::S_FINISH:     cmd.finish     = !sts.out_busy;
            default:               cmd.finish     = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mbg_datapath.sv =====
// ----------------------------------------------------------------------------
// Maze generator datapath
// Cell memory, position stack, neighbor scan, pick logic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbg_datapath (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire  [mbg_pkg::COL_W-1:0]           cell_x,
    input  wire  [mbg_pkg::ROW_W-1:0]           cell_y,
    input  wire  [mbg_pkg::RND_W-1:0]           random_value,
    input  wire  [mbg_pkg::SIZE_W-1:0]          cfg_width,
    input  wire  [mbg_pkg::SIZE_W-1:0]          cfg_height,
    input  mbg_pkg::cmd_t                       cmd,
    output mbg_pkg::sts_t                       sts,
    output logic                                rsp_valid,
    input  wire                                 rsp_ready,
    output logic [2:0]                          status,
    output logic [mbg_pkg::COL_W-1:0]           pos_x,
    output logic [mbg_pkg::ROW_W-1:0]           pos_y,
    output logic [1:0]                          carve_dir,
    output logic [mbg_pkg::CELL_W-1:0]          cell_bits,
    output logic [mbg_pkg::CNT_W-1:0]           visited_count
);

    localparam int CW = mbg_pkg::COL_W;
    localparam int RW = mbg_pkg::ROW_W;
    localparam int AW = mbg_pkg::ADDR_W;
    localparam int NW = mbg_pkg::CNT_W;
    localparam int SW = mbg_pkg::SIZE_W;
    localparam int BW = mbg_pkg::CELL_W;

    // Control state.
    logic [NW-1:0]     depth_reg;
    logic [NW-1:0]     visited_reg;
    logic              started_reg;
    logic [SW-1:0]     act_w_reg;
    logic [SW-1:0]     act_h_reg;
    logic [NW-1:0]     cell_total_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [2:0]        scan_idx_reg;
    logic              cap_en_reg;
    logic              rsp_valid_reg;

    // Payload.
    logic [CW-1:0]     cx_reg;
    logic [RW-1:0]     cy_reg;
    logic [mbg_pkg::RND_W-1:0] rnd_reg;
    logic [CW-1:0]     top_x_reg;
    logic [RW-1:0]     top_y_reg;
    logic [CW-1:0]     new_x_reg;
    logic [RW-1:0]     new_y_reg;
    mbg_pkg::dir_t     dir_reg;
    logic [2:0]        cap_idx_reg;
    logic              cap_inrange_reg;
    logic [3:0]        open_mask_reg;
    logic [BW-1:0]     self_bits_reg;
    logic              read_ok_reg;
    mbg_pkg::status_t  status_reg;
    logic [CW-1:0]     pos_x_reg;
    logic [RW-1:0]     pos_y_reg;
    logic [1:0]        carve_dir_reg;
    logic [BW-1:0]     cell_bits_reg;
    logic [NW-1:0]     visited_count_reg;

    // Combinational.
    logic [SW-1:0]     w_clamp;
    logic [SW-1:0]     h_clamp;
    logic [CW-1:0]     nbr_x;
    logic [RW-1:0]     nbr_y;
    logic              nbr_inrange;
    logic [3:0]        s1;
    logic [2:0]        s2;
    logic [2:0]        s3;
    logic [1:0]        rnd_mod3;
    logic [2:0]        open_cnt;
    logic [1:0]        pick_idx;
    logic [2:0]        seen;
    logic              found;
    mbg_pkg::dir_t     pick_dir;
    logic [CW-1:0]     pick_x;
    logic [RW-1:0]     pick_y;

    logic              cell_we;
    logic [AW-1:0]     cell_waddr;
    logic [BW-1:0]     cell_wdata;
    logic              cell_re;
    logic [AW-1:0]     cell_raddr;
    logic [BW-1:0]     cell_rdata;
    logic              stk_we;
    logic [AW-1:0]     stk_waddr;
    logic [AW-1:0]     stk_wdata;
    logic [AW-1:0]     stk_raddr;
    logic [AW-1:0]     stk_rdata;

    // Size registers: zero reads as one, anything above the grid maximum as the maximum.
    always_comb
    begin
        if (cfg_width == '0)
        begin
            w_clamp = SW'(1);
        end
        else if (cfg_width > SW'(mbg_pkg::MAX_COLUMNS))
        begin
            w_clamp = SW'(mbg_pkg::MAX_COLUMNS);
        end
        else
        begin
            w_clamp = cfg_width;
        end
        if (cfg_height == '0)
        begin
            h_clamp = SW'(1);
        end
        else if (cfg_height > SW'(mbg_pkg::MAX_ROWS))
        begin
            h_clamp = SW'(mbg_pkg::MAX_ROWS);
        end
        else
        begin
            h_clamp = cfg_height;
        end
    end

    // Neighbor address for the current scan slot; out-of-grid slots are masked.
    always_comb
    begin
        nbr_x       = top_x_reg;
        nbr_y       = top_y_reg;
        nbr_inrange = 1'b1;
        case (scan_idx_reg)
            {1'b0, mbg_pkg::DIR_N}:
            begin
                nbr_y       = top_y_reg - RW'(1);
                nbr_inrange = (top_y_reg != '0);
            end
            {1'b0, mbg_pkg::DIR_E}:
            begin
                nbr_x       = top_x_reg + CW'(1);
                nbr_inrange = ((SW'(top_x_reg) + SW'(1)) < act_w_reg);
            end
            {1'b0, mbg_pkg::DIR_S}:
            begin
                nbr_y       = top_y_reg + RW'(1);
                nbr_inrange = ((SW'(top_y_reg) + SW'(1)) < act_h_reg);
            end
            {1'b0, mbg_pkg::DIR_W}:
            begin
                nbr_x       = top_x_reg - CW'(1);
                nbr_inrange = (top_x_reg != '0);
            end
            default:
            begin
                nbr_inrange = 1'b1;
            end
        endcase
    end

    // random mod 3 by folding base-4 digits, since 4 is 1 mod 3.
    always_comb
    begin
        s1 = 4'(rnd_reg[1:0]) + 4'(rnd_reg[3:2]) + 4'(rnd_reg[5:4]) + 4'(rnd_reg[7:6]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        rnd_mod3 = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
    end

    always_comb
    begin
        open_cnt = 3'($countones(open_mask_reg));
        case (open_cnt)
            3'd2:    pick_idx = {1'b0, rnd_reg[0]};
            3'd3:    pick_idx = rnd_mod3;
            3'd4:    pick_idx = rnd_reg[1:0];
            default: pick_idx = 2'd0;
        endcase
        pick_dir = mbg_pkg::DIR_N;
        seen     = 3'd0;
        found    = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (open_mask_reg[i])
            begin
                if (!found && (seen == {1'b0, pick_idx}))
                begin
                    pick_dir = mbg_pkg::dir_t'(2'(i));
                    found    = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
        pick_x = top_x_reg;
        pick_y = top_y_reg;
        case (pick_dir)
            mbg_pkg::DIR_N: pick_y = top_y_reg - RW'(1);
            mbg_pkg::DIR_E: pick_x = top_x_reg + CW'(1);
            mbg_pkg::DIR_S: pick_y = top_y_reg + RW'(1);
            default:        pick_x = top_x_reg - CW'(1);
        endcase
    end

    // Memory port steering.
    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = clr_addr_reg;
        cell_wdata = '0;
        if (cmd.clr_step)
        begin
            cell_we = 1'b1;
        end
        else if (cmd.start_fin)
        begin
            cell_we    = 1'b1;
            cell_waddr = {cy_reg, cx_reg};
            cell_wdata = mbg_pkg::VISITED;
        end
        else if (cmd.wr_top)
        begin
            cell_we    = 1'b1;
            cell_waddr = {top_y_reg, top_x_reg};
            cell_wdata = self_bits_reg | mbg_pkg::open_bit(dir_reg);
        end
        else if (cmd.wr_new)
        begin
            cell_we    = 1'b1;
            cell_waddr = {new_y_reg, new_x_reg};
            cell_wdata = mbg_pkg::VISITED | mbg_pkg::open_bit(mbg_pkg::opposite(dir_reg));
        end
        cell_re    = cmd.scan_issue | cmd.read_issue;
        cell_raddr = cmd.scan_issue ? {nbr_y, nbr_x} : {cy_reg, cx_reg};

        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = {cy_reg, cx_reg};
        if (cmd.start_fin)
        begin
            stk_we = 1'b1;
        end
        else if (cmd.wr_new && (depth_reg != NW'(mbg_pkg::CELLS)))
        begin
            stk_we    = 1'b1;
            stk_waddr = depth_reg[AW-1:0];
            stk_wdata = {new_y_reg, new_x_reg};
        end
        stk_raddr = AW'(depth_reg - NW'(2));
    end

    mbg_ram #(
        .WIDTH (BW),
        .DEPTH (mbg_pkg::CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    mbg_ram #(
        .WIDTH (AW),
        .DEPTH (mbg_pkg::CELLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (cmd.pop_issue),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= '0;
            visited_reg    <= '0;
            started_reg    <= 1'b0;
            act_w_reg      <= SW'(mbg_pkg::MAX_COLUMNS);
            act_h_reg      <= SW'(mbg_pkg::MAX_ROWS);
            cell_total_reg <= NW'(mbg_pkg::CELLS);
            clr_addr_reg   <= '0;
            scan_idx_reg   <= '0;
            cap_en_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            cap_en_reg <= cmd.scan_issue;
            if (cmd.load_item)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + 3'd1;
            end
            if (cmd.start_init)
            begin
                act_w_reg      <= w_clamp;
                act_h_reg      <= h_clamp;
                cell_total_reg <= NW'(w_clamp * h_clamp);
                clr_addr_reg   <= '0;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.start_fin)
            begin
                depth_reg   <= NW'(1);
                visited_reg <= NW'(1);
                started_reg <= 1'b1;
            end
            if (cmd.wr_new)
            begin
                visited_reg <= visited_reg + NW'(1);
                if (depth_reg != NW'(mbg_pkg::CELLS))
                begin
                    depth_reg <= depth_reg + NW'(1);
                end
            end
            if (cmd.pop_issue)
            begin
                depth_reg <= depth_reg - NW'(1);
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cx_reg  <= cell_x;
            cy_reg  <= cell_y;
            rnd_reg <= random_value;
        end
        // The start cell is reduced modulo the grid size by repeated
        // subtraction while the clear sweep runs.
        if (cmd.clr_step)
        begin
            if (SW'(cx_reg) >= act_w_reg)
            begin
                cx_reg <= CW'(SW'(cx_reg) - act_w_reg);
            end
            if (SW'(cy_reg) >= act_h_reg)
            begin
                cy_reg <= RW'(SW'(cy_reg) - act_h_reg);
            end
        end
        if (cmd.start_fin)
        begin
            top_x_reg <= cx_reg;
            top_y_reg <= cy_reg;
        end
        if (cmd.wr_new)
        begin
            top_x_reg <= new_x_reg;
            top_y_reg <= new_y_reg;
        end
        if (cmd.pop_cap)
        begin
            top_x_reg <= stk_rdata[CW-1:0];
            top_y_reg <= stk_rdata[AW-1:CW];
        end
        cap_idx_reg     <= scan_idx_reg;
        cap_inrange_reg <= nbr_inrange;
        if (cap_en_reg)
        begin
            if (cap_idx_reg == mbg_pkg::SCAN_SELF)
            begin
                self_bits_reg <= cell_rdata;
            end
            else
            begin
                open_mask_reg[cap_idx_reg[1:0]] <= cap_inrange_reg
                    && ((cell_rdata & mbg_pkg::VISITED) == '0);
            end
        end
        if (cmd.pick)
        begin
            dir_reg   <= pick_dir;
            new_x_reg <= pick_x;
            new_y_reg <= pick_y;
        end
        if (cmd.read_issue)
        begin
            read_ok_reg <= started_reg && (SW'(cx_reg) < act_w_reg)
                && (SW'(cy_reg) < act_h_reg);
        end
        if (cmd.finish)
        begin
            status_reg        <= cmd.res_status;
            pos_x_reg         <= (depth_reg != '0) ? top_x_reg : '0;
            pos_y_reg         <= (depth_reg != '0) ? top_y_reg : '0;
            carve_dir_reg     <= (cmd.res_status == mbg_pkg::ST_CARVED) ? dir_reg : 2'd0;
            cell_bits_reg     <= ((cmd.res_status == mbg_pkg::ST_READ_DONE) && read_ok_reg)
                                 ? cell_rdata : '0;
            visited_count_reg <= visited_reg;
        end
    end

    assign sts.step_ok   = (depth_reg != '0) && (visited_reg < cell_total_reg);
    assign sts.scan_last = (scan_idx_reg == mbg_pkg::SCAN_SELF);
    assign sts.clr_last  = &clr_addr_reg;
    assign sts.any_open  = |open_mask_reg;
    assign sts.out_busy  = rsp_valid_reg && !rsp_ready;

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign carve_dir     = carve_dir_reg;
    assign cell_bits     = cell_bits_reg;
    assign visited_count = visited_count_reg;

endmodule

`default_nettype wire

// ===== test/maze_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze generator response checker
// Watches the register port and both beat channels. It keeps its own copy of
// the maze, the position stack and the size registers. Every response beat is
// compared field by field with the outcome predicted for the oldest command.
// ----------------------------------------------------------------------------
module maze_response_checker #(
    parameter logic [mbg_pkg::PADDR_W-1:0] WIDTH_ADDR  = 3'd0,
    parameter logic [mbg_pkg::PADDR_W-1:0] HEIGHT_ADDR = 3'd4
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [mbg_pkg::PADDR_W-1:0]   paddr,
    input  wire [mbg_pkg::PDATA_W-1:0]   pwdata,
    input  wire                          pready,
    input  wire                          req_valid,
    input  wire                          req_ready,
    input  wire [1:0]                    opcode,
    input  wire [mbg_pkg::COL_W-1:0]     cell_x,
    input  wire [mbg_pkg::ROW_W-1:0]     cell_y,
    input  wire [mbg_pkg::RND_W-1:0]     random_value,
    input  wire                          rsp_valid,
    input  wire                          rsp_ready,
    input  wire [2:0]                    status,
    input  wire [mbg_pkg::COL_W-1:0]     pos_x,
    input  wire [mbg_pkg::ROW_W-1:0]     pos_y,
    input  wire [1:0]                    carve_dir,
    input  wire [mbg_pkg::CELL_W-1:0]    cell_bits,
    input  wire [mbg_pkg::CNT_W-1:0]     visited_count,
    output int                           fail_count,
    output int                           pending
);

    import mbg_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [COL_W-1:0]    pos_x;
        logic [ROW_W-1:0]    pos_y;
        dir_t                dir;
        logic [CELL_W-1:0]   bits;
        logic [CNT_W-1:0]    visited;
    } carve_outcome_t;

    carve_outcome_t    outcome_q[$];
    logic [CELL_W-1:0] grid [CELLS];
    logic [ADDR_W-1:0] trail [CELLS];
    int                trail_depth;
    int                visited_n;
    int                reg_w;
    int                reg_h;
    int                live_w;
    int                live_h;

    function automatic int fit_size(input int v, input int limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic bit unvisited(input int idx);
        return (grid[idx] & VISITED) == '0;
    endfunction

    task automatic advance_maze(input logic [1:0] op, input int px, input int py,
                                input int rnd, output carve_outcome_t o);
        int                cx;
        int                cy;
        int                top;
        int                tx;
        int                ty;
        int                nx;
        int                ny;
        int                nidx;
        int                n;
        dir_t              cand [4];
        dir_t              d;
        logic [CELL_W-1:0] here_bit;
        logic [CELL_W-1:0] there_bit;
        o = '0;
        o.status = ST_NOOP;
        o.dir = DIR_N;
        if (op == OP_START)
        begin
            live_w = fit_size(reg_w, MAX_COLUMNS);
            live_h = fit_size(reg_h, MAX_ROWS);
            cx = px % live_w;
            cy = py % live_h;
            foreach (grid[i])
                grid[i] = '0;
            grid[cy * MAX_COLUMNS + cx] = VISITED;
            trail[0] = ADDR_W'(cy * MAX_COLUMNS + cx);
            trail_depth = 1;
            visited_n = 1;
            o.status = ST_STARTED;
        end
        else if (op == OP_STEP)
        begin
            if (trail_depth > 0 && visited_n < live_w * live_h)
            begin
                top = int'(trail[trail_depth - 1]);
                tx = top % MAX_COLUMNS;
                ty = top / MAX_COLUMNS;
                n = 0;
                if (ty > 0 && unvisited(top - MAX_COLUMNS))
                begin
                    cand[n] = DIR_N;
                    n++;
                end
                if (tx + 1 < live_w && unvisited(top + 1))
                begin
                    cand[n] = DIR_E;
                    n++;
                end
                if (ty + 1 < live_h && unvisited(top + MAX_COLUMNS))
                begin
                    cand[n] = DIR_S;
                    n++;
                end
                if (tx > 0 && unvisited(top - 1))
                begin
                    cand[n] = DIR_W;
                    n++;
                end
                if (n > 0)
                begin
                    d = cand[rnd % n];
                    nx = tx;
                    ny = ty;
                    case (d)
                        DIR_N:
                        begin
                            ny = ty - 1;
                            here_bit = OPEN_N;
                            there_bit = OPEN_S;
                        end
                        DIR_E:
                        begin
                            nx = tx + 1;
                            here_bit = OPEN_E;
                            there_bit = OPEN_W;
                        end
                        DIR_S:
                        begin
                            ny = ty + 1;
                            here_bit = OPEN_S;
                            there_bit = OPEN_N;
                        end
                        default:
                        begin
                            nx = tx - 1;
                            here_bit = OPEN_W;
                            there_bit = OPEN_E;
                        end
                    endcase
                    nidx = ny * MAX_COLUMNS + nx;
                    grid[nidx] = grid[nidx] | VISITED | there_bit;
                    grid[top] = grid[top] | here_bit;
                    if (trail_depth < CELLS)
                    begin
                        trail[trail_depth] = ADDR_W'(nidx);
                        trail_depth++;
                    end
                    visited_n++;
                    o.status = ST_CARVED;
                    o.dir = d;
                end
                else
                begin
                    trail_depth--;
                    o.status = ST_BACKTRACKED;
                end
            end
        end
        else
        begin
            // The spare opcode behaves as a read.
            o.status = ST_READ_DONE;
            if (px < live_w && py < live_h)
                o.bits = grid[py * MAX_COLUMNS + px];
        end
        if (trail_depth > 0)
        begin
            top = int'(trail[trail_depth - 1]);
            o.pos_x = COL_W'(top % MAX_COLUMNS);
            o.pos_y = ROW_W'(top / MAX_COLUMNS);
        end
        o.visited = CNT_W'(visited_n);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        carve_outcome_t want;
        if (!rst_n)
        begin
            foreach (grid[i])
                grid[i] = '0;
            trail_depth = 0;
            visited_n = 0;
            reg_w = MAX_COLUMNS;
            reg_h = MAX_ROWS;
            live_w = MAX_COLUMNS;
            live_h = MAX_ROWS;
            outcome_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // A response always belongs to a command taken at an earlier edge.
            if (rsp_valid && rsp_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("response beat with no command waiting");
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("pos_x", 16'(want.pos_x), 16'(pos_x));
                    check_field("pos_y", 16'(want.pos_y), 16'(pos_y));
                    check_field("carve_dir", 16'(want.dir), 16'(carve_dir));
                    check_field("cell_bits", 16'(want.bits), 16'(cell_bits));
                    check_field("visited_count", 16'(want.visited), 16'(visited_count));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == WIDTH_ADDR)
                    reg_w = int'(pwdata[SIZE_W-1:0]);
                else if (paddr == HEIGHT_ADDR)
                    reg_h = int'(pwdata[SIZE_W-1:0]);
            end
            if (req_valid && req_ready)
            begin
                advance_maze(opcode, int'(cell_x), int'(cell_y), int'(random_value), want);
                outcome_q.insert(outcome_q.size(), want);
            end
            pending = outcome_q.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze backtracker generator testbench
// Drives a short directed sequence and then random generation phases over
// small and extreme grid sizes, with bursty commands and a stalling receiver.
// The checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    import mbg_pkg::*;

    localparam logic [PADDR_W-1:0] REG_WIDTH_ADDR  = 3'd0;
    localparam logic [PADDR_W-1:0] REG_HEIGHT_ADDR = 3'd4;
    localparam logic [1:0]         OP_READ_ALIAS   = 2'd3;
    localparam int                 COMMAND_TARGET  = 500;
    localparam int                 HOLD_CYCLES     = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic [1:0]           opcode = '0;
    logic [COL_W-1:0]     cell_x = '0;
    logic [ROW_W-1:0]     cell_y = '0;
    logic [RND_W-1:0]     random_value = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic [2:0]           status;
    logic [COL_W-1:0]     pos_x;
    logic [ROW_W-1:0]     pos_y;
    logic [1:0]           carve_dir;
    logic [CELL_W-1:0]    cell_bits;
    logic [CNT_W-1:0]     visited_count;
    int                   fail_count;
    int                   pending;
    int                   burst_left = 0;
    int                   beats_sent = 0;
    bit                   hold_req = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    maze_backtracker_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .opcode        (opcode),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .random_value  (random_value),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .carve_dir     (carve_dir),
        .cell_bits     (cell_bits),
        .visited_count (visited_count)
    );

    maze_response_checker #(
        .WIDTH_ADDR  (REG_WIDTH_ADDR),
        .HEIGHT_ADDR (REG_HEIGHT_ADDR)
    ) maze_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .opcode        (opcode),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .random_value  (random_value),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .carve_dir     (carve_dir),
        .cell_bits     (cell_bits),
        .visited_count (visited_count),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Drop the request and wait until every response beat has been taken.
    task automatic settle();
        req_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input int value);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_cmd(input int op, input int x, input int y, input int rnd);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        req_valid <= 1'b1;
        opcode <= 2'(op);
        cell_x <= COL_W'(x);
        cell_y <= ROW_W'(y);
        random_value <= RND_W'(rnd);
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        burst_left--;
        beats_sent++;
    endtask

    // Receiver: stretches of always ready, random and toggling acceptance,
    // plus one long hold-off that backs the block up into its input.
    initial
    begin : receiver
        int mode;
        int stretch;
        bit hold_done;
        mode = 0;
        stretch = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (stretch == 0)
            begin
                mode = $urandom_range(0, 3);
                stretch = $urandom_range(4, 64);
            end
            stretch--;
            case (mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 1) == 0);
                2: rsp_ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ready <= ~rsp_ready;
            endcase
        end
    end

    initial
    begin : stimulus
        int phase;
        int k;
        int n;
        int r;
        int steps;
        int eff_w;
        int eff_h;
        int wr_w;
        int wr_h;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before any start: a step does nothing and reads see a clear grid.
        send_cmd(OP_STEP, 0, 0, 0);
        send_cmd(OP_READ, 63, 63, 255);
        send_cmd(OP_READ_ALIAS, 0, 0, 0);

        // One row of three from the middle: carve east, backtrack, carve west,
        // then the finished maze ignores steps. The start cell wraps.
        write_reg(REG_WIDTH_ADDR, 3);
        write_reg(REG_HEIGHT_ADDR, 1);
        send_cmd(OP_START, 4, 63, 0);
        send_cmd(OP_STEP, 0, 0, 0);
        send_cmd(OP_STEP, 0, 0, 255);
        send_cmd(OP_STEP, 0, 0, 128);
        send_cmd(OP_STEP, 0, 0, 5);
        send_cmd(OP_READ, 0, 0, 0);
        send_cmd(OP_READ, 1, 0, 0);
        send_cmd(OP_READ, 2, 0, 0);
        send_cmd(OP_READ, 3, 0, 0);

        // Two by two from the corner: south, east, north.
        write_reg(REG_WIDTH_ADDR, 2);
        write_reg(REG_HEIGHT_ADDR, 2);
        send_cmd(OP_START, 0, 0, 255);
        send_cmd(OP_STEP, 0, 0, 255);
        send_cmd(OP_STEP, 0, 0, 255);
        send_cmd(OP_STEP, 0, 0, 255);
        send_cmd(OP_STEP, 0, 0, 255);
        send_cmd(OP_READ, 1, 1, 0);

        // Zero sizes act as one, oversized ones as the maximum.
        write_reg(REG_WIDTH_ADDR, 0);
        write_reg(REG_HEIGHT_ADDR, 0);
        send_cmd(OP_START, 63, 63, 0);
        send_cmd(OP_STEP, 0, 0, 0);
        send_cmd(OP_READ, 0, 0, 0);
        write_reg(REG_WIDTH_ADDR, 127);
        write_reg(REG_HEIGHT_ADDR, 127);
        send_cmd(OP_START, 63, 63, 0);
        send_cmd(OP_STEP, 0, 0, 255);
        send_cmd(OP_READ, 63, 63, 0);

        phase = 0;
        while (beats_sent < COMMAND_TARGET)
        begin
            k = $urandom_range(0, 9);
            eff_w = (k == 0) ? MAX_COLUMNS : (k == 2) ? $urandom_range(7, 40)
                                                      : $urandom_range(1, 6);
            eff_h = (k == 1) ? MAX_ROWS : (k == 3) ? $urandom_range(7, 40)
                                                   : $urandom_range(1, 6);
            wr_w = eff_w;
            wr_h = eff_h;
            if (eff_w == 1 && $urandom_range(0, 1) == 1)
                wr_w = 0;
            if (eff_h == 1 && $urandom_range(0, 1) == 1)
                wr_h = 0;
            if (eff_w == MAX_COLUMNS && $urandom_range(0, 1) == 1)
                wr_w = $urandom_range(MAX_COLUMNS + 1, 127);
            if (eff_h == MAX_ROWS && $urandom_range(0, 1) == 1)
                wr_h = $urandom_range(MAX_ROWS + 1, 127);
            write_reg(REG_WIDTH_ADDR, wr_w);
            write_reg(REG_HEIGHT_ADDR, wr_h);
            send_cmd(OP_START, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);

            // Enough steps to finish a small maze, capped for the big ones.
            steps = 2 * eff_w * eff_h + 2;
            if (steps > 60)
                steps = 60;
            for (n = 0; n < steps; n++)
            begin
                if (phase == 1 && n == 3)
                    hold_req = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 72)
                    send_cmd(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                else if (r < 84)
                    send_cmd(OP_READ, $urandom_range(0, eff_w - 1),
                             $urandom_range(0, eff_h - 1), $urandom);
                else if (r < 89)
                    send_cmd(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                else if (r < 93)
                    send_cmd(OP_READ_ALIAS, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom);
                else if (r < 95)
                    send_cmd(OP_START, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                else if (r < 97)
                    // Sizes written mid-generation only count from the next start.
                    write_reg(($urandom_range(0, 1) == 0) ? REG_WIDTH_ADDR : REG_HEIGHT_ADDR,
                              $urandom_range(0, 127));
                else
                    send_cmd(OP_STEP, 0, 0, ($urandom_range(0, 1) == 0) ? 0 : 255);
            end
            phase++;
        end

        settle();
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("maze_backtracker_generator_core verification clean");
        else
            $display("maze_backtracker_generator_core verification failed");
        $finish;
    end

    // A start sweeps the whole cell memory, so the bound allows for every
    // command being a start under heavy receiver stalls.
    initial
    begin : watchdog
        #20000000;
        $display("maze_backtracker_generator_core verification failed");
        $finish;
    end

endmodule
